// ===== sv/ifr_pkg.sv =====
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types, widths and helpers of the IPv4 filter and prefix router.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifr_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned LINK_W   = 4;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned RCOUNT_W = 6;
  localparam int unsigned FCOUNT_W = 5;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned ENTRY_W  = ADDR_W + LEN_W + LINK_W;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam int unsigned ROUTE_DEPTH_DEF  = 32;
  localparam int unsigned FILTER_DEPTH_DEF = 16;
  localparam int unsigned LINK_COUNT_DEF   = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_WR_ROUTE  = 2'd0,
    REQ_WR_FILTER = 2'd1,
    REQ_PACKET    = 2'd2,
    REQ_READ      = 2'd3
  } req_e;

  typedef enum logic {
    REG_ROUTE_COUNT  = 1'b0,
    REG_FILTER_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [RCOUNT_W-1:0] route_count;
    logic [FCOUNT_W-1:0] filter_count;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
  } entry_t;

  // The length is at most 32 here, as it is clamped when an entry is written.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ipv4_filter_and_prefix_router.sv =====
// ----------------------------------------------------------------------------
// ipv4_filter_and_prefix_router
// IPv4 filter and longest-prefix router with saturating per-link counters.
// ----------------------------------------------------------------------------
// Route and filter entries share one table memory and are scanned one entry
// per cycle through its registered read port. A table write gives no result
// word; a counter read passes through the counter read and update states,
// and a packet first scans the filters and then the routes, or stops early
// when a filter hits. Either of the last two waits in the output state while
// the previous result has not yet left the output register. The block accepts
// a new word once the previous one has finished, while an earlier result may
// still wait in the output register. Counters live in a second memory with a
// valid bit per link, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_filter_and_prefix_router import ifr_pkg::*; #(
  parameter int unsigned ROUTE_DEPTH  = ROUTE_DEPTH_DEF,
  parameter int unsigned FILTER_DEPTH = FILTER_DEPTH_DEF,
  parameter int unsigned LINK_COUNT   = LINK_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [ADDR_W-1:0] prefix_addr_i,
  input  logic [LEN_W-1:0]  prefix_len_i,
  input  logic [LINK_W-1:0] link_id_i,
  input  logic [ADDR_W-1:0] dest_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LINK_W-1:0] out_link_o,
  output logic              rejected_o,
  output logic              matched_o,
  output logic [CNT_W-1:0]  count_value_o
);

  cfg_t cfg;

  ifr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ifr_core #(
    .ROUTE_DEPTH  (ROUTE_DEPTH),
    .FILTER_DEPTH (FILTER_DEPTH),
    .LINK_COUNT   (LINK_COUNT)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .prefix_addr_i (prefix_addr_i),
    .prefix_len_i  (prefix_len_i),
    .link_id_i     (link_id_i),
    .dest_addr_i   (dest_addr_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_link_o    (out_link_o),
    .rejected_o    (rejected_o),
    .matched_o     (matched_o),
    .count_value_o (count_value_o)
  );

endmodule

`default_nettype wire

// ===== sv/ifr_ram.sv =====
// ----------------------------------------------------------------------------
// ifr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ifr_regs.sv =====
// ----------------------------------------------------------------------------
// ifr_regs
// APB-style register file holding the active route and filter counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_regs import ifr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_ROUTE_COUNT:  cfg_q.route_count  <= pwdata[RCOUNT_W-1:0];
        REG_FILTER_COUNT: cfg_q.filter_count <= pwdata[FCOUNT_W-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ROUTE_COUNT:  prdata = APB_DW'(cfg_q.route_count);
      REG_FILTER_COUNT: prdata = APB_DW'(cfg_q.filter_count);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/ifr_core.sv =====
// ----------------------------------------------------------------------------
// ifr_core
// Table and counter memories with the scan sequencer and counter update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_core import ifr_pkg::*; #(
  parameter int unsigned ROUTE_DEPTH  = ROUTE_DEPTH_DEF,
  parameter int unsigned FILTER_DEPTH = FILTER_DEPTH_DEF,
  parameter int unsigned LINK_COUNT   = LINK_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [ADDR_W-1:0] prefix_addr_i,
  input  logic [LEN_W-1:0]  prefix_len_i,
  input  logic [LINK_W-1:0] link_id_i,
  input  logic [ADDR_W-1:0] dest_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LINK_W-1:0] out_link_o,
  output logic              rejected_o,
  output logic              matched_o,
  output logic [CNT_W-1:0]  count_value_o
);

  localparam int unsigned TDEPTH = ROUTE_DEPTH + FILTER_DEPTH;
  localparam int unsigned TAW    = $clog2(TDEPTH);
  localparam int unsigned MAXD   = (ROUTE_DEPTH > FILTER_DEPTH) ? ROUTE_DEPTH : FILTER_DEPTH;
  localparam int unsigned SCW    = $clog2(MAXD + 1);
  localparam int unsigned CAW    = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ROUT,
    ST_CRD,
    ST_CUPD,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [SCW-1:0]     idx_q;
  logic               pend_q;
  logic [ADDR_W-1:0]  dest_q;
  logic               rej_q;
  logic               hit_q;
  logic [LEN_W-1:0]   best_len_q;
  logic [LINK_W-1:0]  chosen_q;
  logic               is_pkt_q;
  logic               link_ok_q;
  logic [CNT_W-1:0]   res_count_q;
  logic [LINK_COUNT-1:0] cnt_vld_q;
  logic               out_valid_q;
  logic [LINK_W-1:0]  out_link_q;
  logic               out_rej_q;
  logic               out_match_q;
  logic [CNT_W-1:0]   out_count_q;

  logic               accept;
  req_e               req;
  logic [SCW-1:0]     nf;
  logic [SCW-1:0]     nr;
  logic [SCW-1:0]     scan_lim;
  logic               issue;
  logic               tbl_we;
  logic [TAW-1:0]     tbl_waddr;
  entry_t             tbl_wdata;
  logic [TAW-1:0]     tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;
  entry_t             ent;
  logic               ent_hit;
  logic [CAW-1:0]     cnt_addr;
  logic [CNT_W-1:0]   cnt_rdata;
  logic [CNT_W-1:0]   cur_cnt;
  logic [CNT_W-1:0]   new_cnt;
  logic               cnt_we;
  logic               wr_route;
  logic               wr_filter;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign req        = req_e'(req_type_i);

  assign nr = (32'(cfg_i.route_count) < ROUTE_DEPTH) ? SCW'(cfg_i.route_count)
                                                     : SCW'(ROUTE_DEPTH);
  assign nf = (32'(cfg_i.filter_count) < FILTER_DEPTH) ? SCW'(cfg_i.filter_count)
                                                       : SCW'(FILTER_DEPTH);
  assign scan_lim = (state_q == ST_FILT) ? nf : nr;
  assign issue    = ((state_q == ST_FILT) || (state_q == ST_ROUT)) && (idx_q < scan_lim);

  // Routes occupy the low part of the table memory, filters follow them.
  assign wr_route  = accept && (req == REQ_WR_ROUTE) && (32'(entry_index_i) < ROUTE_DEPTH);
  assign wr_filter = accept && (req == REQ_WR_FILTER) && (32'(entry_index_i) < FILTER_DEPTH);
  assign tbl_we    = wr_route | wr_filter;
  assign tbl_waddr = wr_route ? TAW'(32'(entry_index_i))
                              : TAW'(ROUTE_DEPTH + 32'(entry_index_i));

  always_comb begin
    tbl_wdata.addr = prefix_addr_i;
    tbl_wdata.len  = (prefix_len_i > MAX_LEN) ? MAX_LEN : prefix_len_i;
    tbl_wdata.link = '0;
    if (wr_route && (32'(link_id_i) < LINK_COUNT)) begin
      tbl_wdata.link = link_id_i;
    end
  end

  assign tbl_raddr = (state_q == ST_FILT) ? TAW'(ROUTE_DEPTH + 32'(idx_q))
                                          : TAW'(32'(idx_q));

  ifr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TDEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign ent     = entry_t'(tbl_rdata);
  assign ent_hit = ((dest_q ^ ent.addr) & prefix_mask(ent.len)) == '0;

  assign cnt_addr = CAW'(32'(chosen_q));
  assign cur_cnt  = (link_ok_q && cnt_vld_q[cnt_addr]) ? cnt_rdata : '0;
  assign new_cnt  = (is_pkt_q && (cur_cnt != CNT_MAX)) ? cur_cnt + 1'b1 : cur_cnt;
  assign cnt_we   = (state_q == ST_CUPD) && is_pkt_q;

  ifr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (LINK_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_addr),
    .wdata_i (new_cnt),
    .raddr_i (cnt_addr),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dest_q     <= dest_addr_i;
            chosen_q   <= (req == REQ_PACKET) ? '0 : link_id_i;
            rej_q      <= 1'b0;
            hit_q      <= 1'b0;
            best_len_q <= '0;
            idx_q      <= '0;
            pend_q     <= 1'b0;
            is_pkt_q   <= (req == REQ_PACKET);
            link_ok_q  <= (req == REQ_PACKET) || (32'(link_id_i) < LINK_COUNT);
            case (req)
              REQ_PACKET: begin
                state_q <= ST_FILT;
              end
              REQ_READ: begin
                state_q <= ST_CRD;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_FILT: begin
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          if (pend_q && ent_hit) begin
            rej_q   <= 1'b1;
            pend_q  <= 1'b0;
            state_q <= ST_CRD;
          end else begin
            pend_q <= issue;
            if (!pend_q && !issue) begin
              idx_q   <= '0;
              state_q <= ST_ROUT;
            end
          end
        end
        ST_ROUT: begin
          pend_q <= issue;
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          if (pend_q && ent_hit && (!hit_q || (ent.len > best_len_q))) begin
            hit_q      <= 1'b1;
            best_len_q <= ent.len;
            chosen_q   <= ent.link;
          end
          if (!pend_q && !issue) begin
            state_q <= ST_CRD;
          end
        end
        ST_CRD: begin
          state_q <= ST_CUPD;
        end
        ST_CUPD: begin
          res_count_q <= new_cnt;
          if (cnt_we) begin
            cnt_vld_q[cnt_addr] <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_link_q  <= chosen_q;
            out_rej_q   <= rej_q;
            out_match_q <= hit_q;
            out_count_q <= res_count_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_link_o    = out_link_q;
  assign rejected_o    = out_rej_q;
  assign matched_o     = out_match_q;
  assign count_value_o = out_count_q;

  a_rej_excludes_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_rej_q && out_match_q))
    else $error("rejected packet also reports a route match");

  a_tbl_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q == ST_IDLE))
    else $error("table written while a packet is in progress");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= MAXD)
    else $error("scan index beyond table depth");

  a_pkt_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CUPD) && is_pkt_q) |=> (res_count_q != '0))
    else $error("packet counter did not advance");

endmodule

`default_nettype wire

// ===== verif/ifr_route_checker.sv =====
// ----------------------------------------------------------------------------
// ifr_route_checker
// Watches the configuration port and both word channels of the IPv4 filter
// and prefix router, keeps its own copy of the tables, the scan counts and
// the per-link counters, predicts the result of every accepted packet or
// counter read and compares each returned word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifr_route_checker import ifr_pkg::*; #(
  parameter int unsigned ROUTE_DEPTH  = ROUTE_DEPTH_DEF,
  parameter int unsigned FILTER_DEPTH = FILTER_DEPTH_DEF,
  parameter int unsigned LINK_COUNT   = LINK_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [ADDR_W-1:0] prefix_addr_i,
  input  logic [LEN_W-1:0]  prefix_len_i,
  input  logic [LINK_W-1:0] link_id_i,
  input  logic [ADDR_W-1:0] dest_addr_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [LINK_W-1:0] out_link_i,
  input  logic              rejected_i,
  input  logic              matched_i,
  input  logic [CNT_W-1:0]  count_value_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              rejected;
    logic              matched;
    logic [CNT_W-1:0]  count;
  } verdict_t;

  entry_t              route_tbl [ROUTE_DEPTH];
  entry_t              filter_tbl[FILTER_DEPTH];
  logic [CNT_W-1:0]    link_cnt  [LINK_COUNT];
  logic [RCOUNT_W-1:0] route_count_q;
  logic [FCOUNT_W-1:0] filter_count_q;
  verdict_t            due_verdicts[$];
  int                  n_err = 0;

  function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
    if (len == '0) begin
      return '0;
    end
    if (len >= MAX_LEN) begin
      return {ADDR_W{1'b1}};
    end
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  function automatic logic [CNT_W-1:0] bump_link(input logic [LINK_W-1:0] link);
    if (link >= LINK_COUNT) begin
      return '0;
    end
    if (link_cnt[link] != CNT_MAX) begin
      link_cnt[link] = link_cnt[link] + 1'b1;
    end
    return link_cnt[link];
  endfunction

  function automatic verdict_t forward_packet(input logic [ADDR_W-1:0] dest);
    verdict_t         v;
    int               nf;
    int               nr;
    int               i;
    logic [LEN_W-1:0] best;
    nf   = (filter_count_q > FILTER_DEPTH) ? FILTER_DEPTH : filter_count_q;
    nr   = (route_count_q > ROUTE_DEPTH) ? ROUTE_DEPTH : route_count_q;
    v    = '0;
    best = '0;
    for (i = 0; i < nf && !v.rejected; i++) begin
      if (((dest ^ filter_tbl[i].addr) & net_mask(filter_tbl[i].len)) == '0) begin
        v.rejected = 1'b1;
      end
    end
    if (!v.rejected) begin
      for (i = 0; i < nr; i++) begin
        if (((dest ^ route_tbl[i].addr) & net_mask(route_tbl[i].len)) == '0 &&
            (!v.matched || route_tbl[i].len > best)) begin
          v.matched = 1'b1;
          best      = route_tbl[i].len;
          v.link    = route_tbl[i].link;
        end
      end
    end
    if (!v.matched) begin
      v.link = '0;
    end
    v.count = bump_link(v.link);
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    n_err++;
    if (n_err <= 100) begin
      $display("[%0t] checker: %s", $time, msg);
    end
  endtask

  task automatic apply_word();
    logic [LEN_W-1:0] len_c;
    verdict_t         v;
    len_c = (prefix_len_i > MAX_LEN) ? MAX_LEN : prefix_len_i;
    case (req_type_i)
      REQ_WR_ROUTE: begin
        if (entry_index_i < ROUTE_DEPTH) begin
          route_tbl[entry_index_i] = '{addr: prefix_addr_i, len: len_c,
              link: (link_id_i < LINK_COUNT) ? link_id_i : {LINK_W{1'b0}}};
        end
      end
      REQ_WR_FILTER: begin
        if (entry_index_i < FILTER_DEPTH) begin
          filter_tbl[entry_index_i] = '{addr: prefix_addr_i, len: len_c,
              link: {LINK_W{1'b0}}};
        end
      end
      REQ_PACKET: begin
        due_verdicts.push_back(forward_packet(dest_addr_i));
      end
      default: begin
        v       = '0;
        v.link  = link_id_i;
        v.count = (link_id_i < LINK_COUNT) ? link_cnt[link_id_i] : {CNT_W{1'b0}};
        due_verdicts.push_back(v);
      end
    endcase
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (due_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected word: link %0d rejected %0b matched %0b count %0d",
                                out_link_i, rejected_i, matched_i, count_value_i));
    end else begin
      want = due_verdicts.pop_front();
      if (out_link_i !== want.link) begin
        report_mismatch($sformatf("out_link %0d, expected %0d", out_link_i, want.link));
      end
      if (rejected_i !== want.rejected) begin
        report_mismatch($sformatf("rejected %0b, expected %0b", rejected_i, want.rejected));
      end
      if (matched_i !== want.matched) begin
        report_mismatch($sformatf("matched %0b, expected %0b", matched_i, want.matched));
      end
      if (count_value_i !== want.count) begin
        report_mismatch($sformatf("count_value %0d, expected %0d", count_value_i, want.count));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (route_tbl[i]) begin
        route_tbl[i] = '0;
      end
      foreach (filter_tbl[i]) begin
        filter_tbl[i] = '0;
      end
      foreach (link_cnt[i]) begin
        link_cnt[i] = '0;
      end
      route_count_q  = '0;
      filter_count_q = '0;
      due_verdicts.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[2]))
          REG_ROUTE_COUNT:  route_count_q  = pwdata[RCOUNT_W-1:0];
          REG_FILTER_COUNT: filter_count_q = pwdata[FCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        check_verdict();
      end
      if (in_valid_i && in_ready_i) begin
        apply_word();
      end
      errors_o  <= n_err;
      pending_o <= due_verdicts.size();
    end
  end

endmodule

// ===== verif/tb_ipv4_filter_and_prefix_router.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_filter_and_prefix_router
// Testbench top of the IPv4 filter and prefix router.
// Drives table writes, packets and counter reads with random idle gaps on
// both channels, changes the scan counts over the configuration port while
// the block is idle, and gives the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv4_filter_and_prefix_router;
  import ifr_pkg::*;

  localparam int ROUTES        = ROUTE_DEPTH_DEF;
  localparam int FILTERS       = FILTER_DEPTH_DEF;
  localparam int ITEM_TARGET   = 1400;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 800_000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [REQ_W-1:0]  req_type_i;
  logic [SLOT_W-1:0] entry_index_i;
  logic [ADDR_W-1:0] prefix_addr_i;
  logic [LEN_W-1:0]  prefix_len_i;
  logic [LINK_W-1:0] link_id_i;
  logic [ADDR_W-1:0] dest_addr_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [LINK_W-1:0] out_link_o;
  logic              rejected_o;
  logic              matched_o;
  logic [CNT_W-1:0]  count_value_o;

  int errors;
  int pending;
  int cycles = 0;
  bit calm   = 1'b0;
  int words_sent = 0;
  int scan_routes = 0;
  int scan_filters = 0;

  logic [ADDR_W-1:0] route_addr [ROUTES];
  logic [LEN_W-1:0]  route_len  [ROUTES];
  logic [ADDR_W-1:0] filter_addr[FILTERS];
  logic [LEN_W-1:0]  filter_len [FILTERS];
  logic [ADDR_W-1:0] base_pool  [4];

  ipv4_filter_and_prefix_router uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .req_type_i, .entry_index_i, .prefix_addr_i,
    .prefix_len_i, .link_id_i, .dest_addr_i, .out_valid_o, .out_ready_i,
    .out_link_o, .rejected_o, .matched_o, .count_value_o
  );

  ifr_route_checker route_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .prefix_addr_i (prefix_addr_i),
    .prefix_len_i  (prefix_len_i),
    .link_id_i     (link_id_i),
    .dest_addr_i   (dest_addr_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_link_i    (out_link_o),
    .rejected_i    (rejected_o),
    .matched_i     (matched_o),
    .count_value_i (count_value_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm) begin
      return 0;
    end
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic put_word(input req_e kind, input logic [SLOT_W-1:0] slot,
                          input logic [ADDR_W-1:0] pa, input logic [LEN_W-1:0] pl,
                          input logic [LINK_W-1:0] lk, input logic [ADDR_W-1:0] dest);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_index_i <= slot;
    prefix_addr_i <= pa;
    prefix_len_i  <= pl;
    link_id_i     <= lk;
    dest_addr_i   <= dest;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e r, input int value);
    int width;
    width   = (r == REG_ROUTE_COUNT) ? RCOUNT_W : FCOUNT_W;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DW'(value) | ($urandom() << width);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_scan(input int rc, input int fc);
    settle();
    apb_write(REG_ROUTE_COUNT, rc);
    apb_write(REG_FILTER_COUNT, fc);
    scan_routes  = (rc > ROUTES) ? ROUTES : rc;
    scan_filters = (fc > FILTERS) ? FILTERS : fc;
  endtask

  task automatic write_route(input int slot, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len, input logic [LINK_W-1:0] link);
    route_addr[slot] = addr;
    route_len[slot]  = (len > MAX_LEN) ? MAX_LEN : len;
    put_word(REQ_WR_ROUTE, slot, addr, len, link, $urandom());
  endtask

  task automatic write_filter(input int slot, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len);
    if (slot < FILTERS) begin
      filter_addr[slot] = addr;
      filter_len[slot]  = (len > MAX_LEN) ? MAX_LEN : len;
    end
    put_word(REQ_WR_FILTER, slot, addr, len, $urandom_range(0, 15), $urandom());
  endtask

  task automatic send_packet(input logic [ADDR_W-1:0] dest);
    put_word(REQ_PACKET, $urandom_range(0, 31), $urandom(), $urandom_range(0, 63),
             $urandom_range(0, 15), dest);
  endtask

  task automatic read_link(input logic [LINK_W-1:0] link);
    put_word(REQ_READ, $urandom_range(0, 31), $urandom(), $urandom_range(0, 63), link,
             $urandom());
  endtask

  task automatic random_route(input int slot);
    write_route(slot, base_pool[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(0, 32)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32),
                $urandom_range(0, 15));
  endtask

  task automatic random_filter(input int slot);
    logic [ADDR_W-1:0] addr;
    addr = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      addr = base_pool[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(8, 32));
    end
    write_filter(slot, addr,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(18, 32));
  endtask

  function automatic logic [ADDR_W-1:0] host_bits(input logic [LEN_W-1:0] len);
    return (len >= MAX_LEN) ? {ADDR_W{1'b0}} : ({ADDR_W{1'b1}} >> len);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_dest();
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] h;
    int                k;
    d = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (scan_routes > 0) begin
          k = $urandom_range(0, scan_routes - 1);
          h = host_bits(route_len[k]);
          d = (route_addr[k] & ~h) | (d & h);
        end
      end
      5, 6: begin
        if (scan_filters > 0) begin
          k = $urandom_range(0, scan_filters - 1);
          h = host_bits(filter_len[k]);
          d = (filter_addr[k] & ~h) | (d & h);
        end
      end
      7: d = $urandom_range(0, 1) ? {ADDR_W{1'b1}} : {ADDR_W{1'b0}};
      default: ;
    endcase
    return d;
  endfunction

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick <= 10) begin
      send_packet(pick_dest());
    end else if (pick <= 12) begin
      read_link($urandom_range(0, 15));
    end else if (pick <= 16) begin
      random_route($urandom_range(0, ROUTES - 1));
    end else if (pick <= 18) begin
      random_filter($urandom_range(0, FILTERS - 1));
    end else begin
      write_filter($urandom_range(FILTERS, 31), $urandom(), $urandom_range(0, 63));
    end
  endtask

  initial begin
    int rc;
    int fc;
    int phase;
    int n;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_WR_ROUTE;
    entry_index_i = '0;
    prefix_addr_i = '0;
    prefix_len_i  = '0;
    link_id_i     = '0;
    dest_addr_i   = '0;
    foreach (base_pool[i]) begin
      base_pool[i] = $urandom();
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With both scan counts at zero a packet matches nothing.
    send_packet(32'h0000_0000);
    read_link(4'd0);
    read_link(4'd15);
    write_route(0, 32'h0000_0000, 6'd0, 4'd3);
    write_route(1, 32'h0A00_0000, 6'd8, 4'd5);
    write_route(2, 32'h0A01_0000, 6'd16, 4'd7);
    write_route(3, 32'h0A01_0203, 6'd63, 4'd15);
    write_route(4, 32'h0A01_FFFF, 6'd16, 4'd9);
    write_route(31, 32'hFFFF_FFFF, 6'd32, 4'd0);
    write_filter(0, 32'hC0A8_0000, 6'd16);
    write_filter(1, 32'hFFFF_FFFF, 6'd40);
    write_filter(31, 32'h0A00_0000, 6'd8);
    set_scan(5, 2);
    send_packet(32'h0A01_0203);
    send_packet(32'h0A01_0900);
    send_packet(32'h0AC8_0001);
    send_packet(32'h0808_0808);
    send_packet(32'hC0A8_0101);
    send_packet(32'hFFFF_FFFF);
    read_link(4'd7);
    read_link(4'd0);

    // Fill both tables so that any scan count is legal from here on.
    for (int i = 0; i < ROUTES; i++) begin
      random_route(i);
    end
    for (int i = 0; i < FILTERS; i++) begin
      random_filter(i);
    end

    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      case (phase)
        0: begin
          rc = 63;
          fc = 31;
        end
        1: begin
          rc = 0;
          fc = 0;
        end
        2: begin
          rc = 32;
          fc = 16;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: rc = 0;
            1: rc = $urandom_range(33, 63);
            2: rc = 32;
            default: rc = $urandom_range(1, 31);
          endcase
          case ($urandom_range(0, 5))
            0: fc = 0;
            1: fc = $urandom_range(17, 31);
            2: fc = 16;
            default: fc = $urandom_range(1, 15);
          endcase
        end
      endcase
      set_scan(rc, fc);
      calm = ($urandom_range(0, 3) == 0);
      n    = $urandom_range(30, 70);
      repeat (n) random_word();
      phase++;
    end

    calm = 1'b0;
    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
